@@ hw/rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty when synthesised.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Plain clocked property, held off while in reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Antecedent in this cycle implies the consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    `ASSERT_CLK(label, clk, rst_n, (ante) |-> (cons))

// Antecedent in this cycle implies the consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    `ASSERT_CLK(label, clk, rst_n, (ante) |=> (cons))

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hw/rtl/mee_pkg.sv @@
// ---------------------------------------------------------------------------
// mee_pkg
// Types, step numbers and microcode table of the MIDI event encoder.
// ---------------------------------------------------------------------------
package mee_pkg;

    typedef logic [3:0] step_t;

    // Program steps
    localparam step_t STEP_IDLE = 4'd0;
    localparam step_t STEP_D3   = 4'd1;
    localparam step_t STEP_D2   = 4'd2;
    localparam step_t STEP_D1   = 4'd3;
    localparam step_t STEP_D0   = 4'd4;
    localparam step_t STEP_ST   = 4'd5;
    localparam step_t STEP_P1   = 4'd6;
    localparam step_t STEP_P2   = 4'd7;
    localparam step_t STEP_L3   = 4'd8;
    localparam step_t STEP_L2   = 4'd9;
    localparam step_t STEP_L1   = 4'd10;
    localparam step_t STEP_L0   = 4'd11;
    localparam step_t STEP_PAY  = 4'd12;

    // Byte source of a step
    typedef enum logic [2:0] {
        SRC_DELTA,
        SRC_LEN,
        SRC_STATUS,
        SRC_P1,
        SRC_P2,
        SRC_DATA
    } src_t;

    // Condition under which a step emits; otherwise it jumps
    typedef enum logic [3:0] {
        C_ALWAYS,
        C_D3,
        C_D2,
        C_D1,
        C_STAT,
        C_P1,
        C_P2,
        C_L3,
        C_L2,
        C_L1,
        C_REM
    } cond_t;

    // Condition under which the emitted byte closes the event
    typedef enum logic [2:0] {
        E_NONE,
        E_NOSTAT_NODATA,
        E_NODATA,
        E_ONEBYTE,
        E_ALWAYS,
        E_LENZERO,
        E_REMONE
    } endc_t;

    typedef struct packed {
        src_t        src;
        logic [1:0]  grp;
        cond_t       cond;
        endc_t       endc;
        logic        done;
        step_t       jmp;
    } ctl_t;

    // Datapath flags back to the sequencer
    typedef struct packed {
        logic cond;
        logic endv;
        logic slot_free;
    } flags_t;

    localparam int VlqBits = 28;

    function automatic ctl_t rom_word(input step_t step);
        ctl_t w;
        w = '{src: SRC_DELTA, grp: 2'd0, cond: C_ALWAYS, endc: E_NONE,
              done: 1'b1, jmp: STEP_IDLE};
        unique case (step)
            STEP_D3:  w = '{SRC_DELTA,  2'd3, C_D3,     E_NONE,          1'b0, STEP_D2};
            STEP_D2:  w = '{SRC_DELTA,  2'd2, C_D2,     E_NONE,          1'b0, STEP_D1};
            STEP_D1:  w = '{SRC_DELTA,  2'd1, C_D1,     E_NONE,          1'b0, STEP_D0};
            STEP_D0:  w = '{SRC_DELTA,  2'd0, C_ALWAYS, E_NOSTAT_NODATA, 1'b0, STEP_ST};
            STEP_ST:  w = '{SRC_STATUS, 2'd0, C_STAT,   E_NODATA,        1'b0, STEP_P1};
            STEP_P1:  w = '{SRC_P1,     2'd0, C_P1,     E_ONEBYTE,       1'b0, STEP_L3};
            STEP_P2:  w = '{SRC_P2,     2'd0, C_P2,     E_ALWAYS,        1'b1, STEP_L3};
            STEP_L3:  w = '{SRC_LEN,    2'd3, C_L3,     E_NONE,          1'b0, STEP_L2};
            STEP_L2:  w = '{SRC_LEN,    2'd2, C_L2,     E_NONE,          1'b0, STEP_L1};
            STEP_L1:  w = '{SRC_LEN,    2'd1, C_L1,     E_NONE,          1'b0, STEP_L0};
            STEP_L0:  w = '{SRC_LEN,    2'd0, C_ALWAYS, E_LENZERO,       1'b1, STEP_IDLE};
            STEP_PAY: w = '{SRC_DATA,   2'd0, C_REM,    E_REMONE,        1'b1, STEP_IDLE};
            default:  w = '{SRC_DELTA,  2'd0, C_ALWAYS, E_NONE,          1'b1, STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

@@ hw/rtl/mee_sequencer.sv @@
// ---------------------------------------------------------------------------
// mee_sequencer
// Step counter and microcode table; emits, holds or jumps per step.
// ---------------------------------------------------------------------------
module mee_sequencer
    import mee_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   accept,
    input  logic   mode,
    input  flags_t flags,
    output ctl_t   ctl,
    output logic   idle,
    output logic   emit
);

    step_t step_reg;
    step_t step_next;

    assign ctl  = rom_word(step_reg);
    assign idle = (step_reg == STEP_IDLE);

    always_comb begin
        step_next = step_reg;
        emit      = 1'b0;
        if (idle) begin
            if (accept) begin
                step_next = mode ? STEP_PAY : STEP_D3;
            end
        end else if (flags.cond) begin
            // hold until the output register can take the byte
            if (flags.slot_free) begin
                emit      = 1'b1;
                step_next = (flags.endv || ctl.done) ? STEP_IDLE : step_reg + step_t'(1);
            end
        end else begin
            step_next = ctl.jmp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

@@ hw/rtl/mee_datapath.sv @@
// ---------------------------------------------------------------------------
// mee_datapath
// Item registers, running status, byte select and output register.
// ---------------------------------------------------------------------------
module mee_datapath
    import mee_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic                mode,
    input  logic [VlqBits-1:0]  delta_time,
    input  logic [7:0]          status,
    input  logic [7:0]          param_one,
    input  logic [7:0]          param_two,
    input  logic [VlqBits-1:0]  payload_length,
    input  logic [7:0]          data_byte,
    input  ctl_t                ctl,
    input  logic                emit,
    output flags_t              flags,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tlast
);

    logic [VlqBits-1:0] delta_reg;
    logic [7:0]         status_reg;
    logic [7:0]         p1_reg;
    logic [7:0]         p2_reg;
    logic [VlqBits-1:0] len_reg;
    logic [7:0]         data_reg;
    logic               stat_emit_reg;
    logic [7:0]         last_status_reg;
    logic [VlqBits-1:0] remaining_reg;
    logic [VlqBits-1:0] remaining_next;
    logic               out_valid_reg;
    logic [7:0]         out_byte_reg;
    logic               out_last_reg;

    logic [3:0]         hi;
    logic               two_byte;
    logic               one_byte;
    logic [7:0]         byte_sel;
    logic               cond_flag;
    logic               endv_flag;

    function automatic logic [7:0] vlq_group(input logic [VlqBits-1:0] v,
                                             input logic [1:0] grp);
        logic [6:0] g;
        case (grp)
            2'd0:    g = v[6:0];
            2'd1:    g = v[13:7];
            2'd2:    g = v[20:14];
            default: g = v[27:21];
        endcase
        return {(grp != 2'd0), g};
    endfunction

    assign hi       = status_reg[7:4];
    assign two_byte = (hi == 4'h8) || (hi == 4'h9) || (hi == 4'hA) || (hi == 4'hB) ||
                      (hi == 4'hE);
    assign one_byte = (hi == 4'hC) || (hi == 4'hD);

    always_comb begin
        unique case (ctl.cond)
            C_ALWAYS: cond_flag = 1'b1;
            C_D3:     cond_flag = (delta_reg[27:21] != '0);
            C_D2:     cond_flag = (delta_reg[27:14] != '0);
            C_D1:     cond_flag = (delta_reg[27:7] != '0);
            C_STAT:   cond_flag = stat_emit_reg;
            C_P1:     cond_flag = two_byte || one_byte || (status_reg == 8'hFF);
            C_P2:     cond_flag = two_byte;
            C_L3:     cond_flag = (len_reg[27:21] != '0);
            C_L2:     cond_flag = (len_reg[27:14] != '0);
            C_L1:     cond_flag = (len_reg[27:7] != '0);
            C_REM:    cond_flag = (remaining_reg != '0);
            default:  cond_flag = 1'b0;
        endcase
    end

    always_comb begin
        unique case (ctl.endc)
            E_NONE:          endv_flag = 1'b0;
            E_NOSTAT_NODATA: endv_flag = !stat_emit_reg && !status_reg[7];
            E_NODATA:        endv_flag = !status_reg[7];
            E_ONEBYTE:       endv_flag = one_byte;
            E_ALWAYS:        endv_flag = 1'b1;
            E_LENZERO:       endv_flag = (len_reg == '0);
            E_REMONE:        endv_flag = (remaining_reg == VlqBits'(1));
            default:         endv_flag = 1'b0;
        endcase
    end

    assign flags = '{cond: cond_flag, endv: endv_flag,
                     slot_free: (!out_valid_reg || m_tready)};

    always_comb begin
        unique case (ctl.src)
            SRC_DELTA:  byte_sel = vlq_group(delta_reg, ctl.grp);
            SRC_LEN:    byte_sel = vlq_group(len_reg, ctl.grp);
            SRC_STATUS: byte_sel = status_reg;
            SRC_P1:     byte_sel = p1_reg;
            SRC_P2:     byte_sel = p2_reg;
            SRC_DATA:   byte_sel = data_reg;
            default:    byte_sel = data_reg;
        endcase
    end

    always_comb begin
        remaining_next = remaining_reg;
        if (accept && !mode) begin
            // a header abandons any payload still expected
            remaining_next = (status[7:4] == 4'hF) ? payload_length : '0;
        end else if (emit && (ctl.src == SRC_DATA)) begin
            remaining_next = remaining_reg - VlqBits'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            delta_reg <= delta_time;
            p1_reg    <= param_one;
            p2_reg    <= param_two;
            len_reg   <= payload_length;
            data_reg  <= data_byte;
        end
        if (emit) begin
            out_byte_reg <= byte_sel;
            out_last_reg <= endv_flag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg      <= '0;
            stat_emit_reg   <= 1'b0;
            last_status_reg <= '0;
            remaining_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (accept && !mode) begin
                status_reg      <= status;
                stat_emit_reg   <= (status != last_status_reg) || (status >= 8'hF0);
                last_status_reg <= status;
            end
            remaining_reg <= remaining_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ hw/rtl/midi_event_encoder.sv @@
// ---------------------------------------------------------------------------
// midi_event_encoder
// MIDI track event serialiser with running status and VLQ encoding.
// ---------------------------------------------------------------------------
// Usage:
//   Slave channel: one request is either an event header (s_tuser = 0) or one
//   payload byte of a sysex/meta event (s_tuser = 1). s_tready is high only
//   while the sequencer sits at its idle step, so one request is worked on
//   at a time.
//   Master channel: one encoded byte per request, m_tlast on the final byte
//   of an event (on the last payload byte for sysex/meta with a payload).
//   Sequence: a header walks the microprogram one step a clock, skipped
//   steps included, except that an emitting step waits while the output
//   register holds an untaken byte: delta groups, status, data or type
//   bytes, length groups, emitting 1 to 10 bytes, then back to the idle
//   step. A payload byte takes a single step. The step counter and its
//   table of control words set this order. The first byte on m_tdata is
//   the most significant delta group that is sent.
//   A payload byte with nothing outstanding is dropped without output.
//   Reset clears the step counter, running status, payload count and output
//   valid. When the receiver stalls, the output register holds its byte and
//   the sequencer waits at the emitting step; nothing is lost.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module midi_event_encoder
    import mee_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // bits [27:0] delta_time, [35:28] status, [43:36] param_one,
    // [51:44] param_two, [79:52] payload_length, [87:80] data_byte
    input  logic [87:0] s_tdata,
    // bit [0] mode
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // bits [7:0] out_byte
    output logic [7:0]  m_tdata,
    // end_of_event
    output logic        m_tlast
);

    ctl_t   ctl;
    flags_t flags;
    logic   idle;
    logic   emit;
    logic   accept;

    // accept only at the idle step
    assign s_tready = idle;
    assign accept   = s_tvalid && s_tready;

    mee_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .mode    (s_tuser),
        .flags   (flags),
        .ctl     (ctl),
        .idle    (idle),
        .emit    (emit)
    );

    mee_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .mode           (s_tuser),
        .delta_time     (s_tdata[27:0]),
        .status         (s_tdata[35:28]),
        .param_one      (s_tdata[43:36]),
        .param_two      (s_tdata[51:44]),
        .payload_length (s_tdata[79:52]),
        .data_byte      (s_tdata[87:80]),
        .ctl            (ctl),
        .emit           (emit),
        .flags          (flags),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast)
    );

    // A request leaves the idle step at once
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, accept, !s_tready)
    // Bytes come only from a running program
    `ASSERT_IMPLY(a_emit_not_idle, aclk, aresetn, emit, !idle)
    // Never overwrite a byte the receiver has not taken
    `ASSERT_IMPLY(a_emit_slot_free, aclk, aresetn, emit, !m_tvalid || m_tready)

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the MIDI track event serialiser.
// Every accepted request is run through an in-bench encoder that builds the
// expected track bytes (VLQ delta, running status, data bytes, length VLQ,
// payload pass-through). Each byte leaving the block is compared with the
// oldest expected byte. A short table of hand-written events comes first,
// then random event sequences under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Request kinds carried on s_tuser
    localparam logic MODE_HDR = 1'b0;
    localparam logic MODE_PAY = 1'b1;

    // Status classes (high nibble of the status byte)
    localparam logic [3:0] CLS_NOTE_OFF = 4'h8;
    localparam logic [3:0] CLS_NOTE_ON  = 4'h9;
    localparam logic [3:0] CLS_POLY_AT  = 4'hA;
    localparam logic [3:0] CLS_CTRL     = 4'hB;
    localparam logic [3:0] CLS_PROG     = 4'hC;
    localparam logic [3:0] CLS_CHAN_AT  = 4'hD;
    localparam logic [3:0] CLS_BEND     = 4'hE;
    localparam logic [3:0] CLS_SYSTEM   = 4'hF;

    // Status bytes on channel 0
    localparam logic [7:0] ST_NOTE_OFF   = 8'h80;
    localparam logic [7:0] ST_NOTE_ON    = 8'h90;
    localparam logic [7:0] ST_POLY_AT    = 8'hA0;
    localparam logic [7:0] ST_CTRL       = 8'hB0;
    localparam logic [7:0] ST_PROG       = 8'hC0;
    localparam logic [7:0] ST_CHAN_AT    = 8'hD0;
    localparam logic [7:0] ST_BEND       = 8'hE0;
    localparam logic [7:0] ST_SYSEX      = 8'hF0;
    localparam logic [7:0] ST_SYSEX_ESC  = 8'hF7;
    localparam logic [7:0] ST_CLOCK      = 8'hF8;
    localparam logic [7:0] ST_META       = 8'hFF;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 20;

    typedef struct packed {
        logic        mode;
        logic [27:0] delta;
        logic [7:0]  status;
        logic [7:0]  p1;
        logic [7:0]  p2;
        logic [27:0] len;
        logic [7:0]  data;
    } item_t;

    // One row of stimulus; when known is set the expected bytes are typed in
    // (first byte in the highest of the n used bytes), otherwise predicted.
    typedef struct packed {
        item_t       it;
        logic        known;
        logic [3:0]  n;
        logic        mark;
        logic [87:0] bytes;
    } req_row_t;

    typedef struct packed {
        logic [7:0] val;
        logic       last;
    } enc_byte_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // bits [27:0] delta_time, [35:28] status, [43:36] param_one,
    // [51:44] param_two, [79:52] payload_length, [87:80] data_byte
    logic [87:0] s_tdata;
    // bit [0] mode
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // bits [7:0] out_byte
    logic [7:0]  m_tdata;
    // end_of_event
    logic        m_tlast;

    // Encoder state mirrored by the bench
    logic [7:0]  run_status;
    logic [27:0] pay_left;

    enc_byte_t   ev_bytes[$];       // bytes of the request just encoded
    enc_byte_t   pending_bytes[$];  // track bytes still owed by the block
    req_row_t    dir_tab[$];

    int          gap_pct   = 0;
    int          stall_pct = 0;
    logic        hold_req  = 1'b0;
    int          events_sent = 0;
    int          mismatches  = 0;
    int          cycles      = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    midi_event_encoder u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // ------------------------------------------------------------------------
    // Encoder model
    // ------------------------------------------------------------------------

    // Append a value as a VLQ, most significant 7-bit group first; 28 bits
    // never need more than four groups.
    function automatic void put_vlq(input logic [27:0] v);
        int groups;
        groups = 1;
        while (groups < 4 && (v >> (7 * groups)) != 28'd0)
            groups++;
        for (int k = groups - 1; k >= 0; k--)
            ev_bytes.push_back('{{k > 0, v[7 * k +: 7]}, 1'b0});
    endfunction

    // Work out the track bytes one request causes and advance the mirrored
    // running status and payload count.
    function automatic void encode_event(input item_t it);
        logic close_evt;
        close_evt = 1'b1;
        ev_bytes.delete();
        if (it.mode == MODE_PAY) begin
            // a payload byte with nothing outstanding simply vanishes
            if (pay_left != 28'd0) begin
                pay_left = pay_left - 28'd1;
                ev_bytes.push_back('{it.data, pay_left == 28'd0});
            end
            return;
        end
        // a new header abandons whatever payload was still owed
        pay_left = 28'd0;
        put_vlq(it.delta);
        if (it.status != run_status || it.status >= ST_SYSEX)
            ev_bytes.push_back('{it.status, 1'b0});
        run_status = it.status;
        case (it.status[7:4])
            CLS_NOTE_OFF, CLS_NOTE_ON, CLS_POLY_AT, CLS_CTRL, CLS_BEND: begin
                ev_bytes.push_back('{it.p1, 1'b0});
                ev_bytes.push_back('{it.p2, 1'b0});
            end
            CLS_PROG, CLS_CHAN_AT: begin
                ev_bytes.push_back('{it.p1, 1'b0});
            end
            CLS_SYSTEM: begin
                if (it.status == ST_META)
                    ev_bytes.push_back('{it.p1, 1'b0});
                put_vlq(it.len);
                pay_left = it.len;
                // with a payload to come, the last payload byte closes it
                if (it.len != 28'd0)
                    close_evt = 1'b0;
            end
            default: ;  // not a status byte: no data bytes
        endcase
        if (close_evt)
            ev_bytes[ev_bytes.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic item_t hdr_item(input logic [27:0] delta, input logic [7:0] status,
                                       input logic [7:0] p1, input logic [7:0] p2,
                                       input logic [27:0] len);
        return '{MODE_HDR, delta, status, p1, p2, len, 8'h00};
    endfunction

    function automatic item_t pay_item(input logic [7:0] data);
        return '{MODE_PAY, 28'd0, 8'h00, 8'h00, 8'h00, 28'd0, data};
    endfunction

    // VLQ-sized random value: spread over one to four groups, now and then
    // the saturated all-ones value.
    function automatic logic [27:0] rand_vlq();
        int          groups;
        logic [27:0] v;
        groups = $urandom_range(1, 4);
        v = 28'($urandom);
        if ($urandom_range(9) == 0)
            return 28'hFFFFFFF;
        return v >> (28 - 7 * groups);
    endfunction

    // Offer one request from a falling edge, hold it until the block takes it,
    // record the expected bytes, and return on the next falling edge.
    task automatic send_req(input req_row_t r);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.it.mode;
        s_tdata  <= {r.it.data, r.it.len, r.it.p2, r.it.p1, r.it.status, r.it.delta};
        do
            @(posedge aclk);
        while (!s_tready);
        // taken at this edge; ignored payload bytes do not count as events
        if (r.it.mode == MODE_HDR || pay_left != 28'd0)
            events_sent++;
        encode_event(r.it);
        if (r.known) begin
            for (int k = 0; k < int'(r.n); k++)
                pending_bytes.push_back('{r.bytes[8 * (int'(r.n) - 1 - k) +: 8],
                                         r.mark && k == int'(r.n) - 1});
        end else begin
            foreach (ev_bytes[k])
                pending_bytes.push_back(ev_bytes[k]);
        end
        @(negedge aclk);
    endtask

    // Drop valid and wait on falling edges until every owed byte has arrived;
    // always step on by at least one falling edge.
    task automatic drain_track();
        s_tvalid <= 1'b0;
        do
            @(negedge aclk);
        while (pending_bytes.size() != 0);
    endtask

    // One random event: a header, then for a system status its payload, mostly
    // complete, sometimes cut short by the next header. Now and then a lone
    // payload byte, dropped by the block when nothing is outstanding.
    task automatic send_random_event();
        req_row_t r;
        int       pick;
        int       npay;
        r = '0;
        r.it.mode  = MODE_HDR;
        r.it.delta = rand_vlq();
        r.it.p1    = 8'($urandom);
        r.it.p2    = 8'($urandom);
        r.it.data  = 8'($urandom);
        r.it.len   = ($urandom_range(9) < 7) ? 28'($urandom_range(0, 4)) : rand_vlq();
        pick = $urandom_range(99);
        if (pick < 6) begin
            r.it.mode = MODE_PAY;
            send_req(r);
            return;
        end else if (pick < 18) begin
            r.it.status = run_status;  // repeat: running status applies below 0xF0
        end else if (pick < 62) begin
            r.it.status = {4'($urandom_range(CLS_NOTE_OFF, CLS_BEND)), 4'($urandom)};
        end else if (pick < 74) begin
            r.it.status = ($urandom_range(1) == 0) ? ST_SYSEX : ST_SYSEX_ESC;
        end else if (pick < 88) begin
            r.it.status = ST_META;
        end else if (pick < 94) begin
            r.it.status = {CLS_SYSTEM, 4'($urandom)};
        end else begin
            r.it.status = 8'($urandom_range(0, 8'h7F));
        end
        send_req(r);
        if (pay_left > 28'd8)
            npay = $urandom_range(0, 3);
        else if ($urandom_range(9) < 8)
            npay = int'(pay_left);
        else
            npay = $urandom_range(0, int'(pay_left));
        repeat (npay) begin
            // unused fields carry noise
            r.it = '{MODE_PAY, 28'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     28'($urandom), 8'($urandom)};
            send_req(r);
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++) begin
                    m_tready <= 1'b0;
                    @(negedge aclk);
                end
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Byte checker
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        enc_byte_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_bytes.size() == 0) begin
                $display("%0t: byte with none owed: got byte %02h last %0b",
                         $time, m_tdata, m_tlast);
                mismatches++;
            end else begin
                want = pending_bytes.pop_front();
                if (m_tdata !== want.val || m_tlast !== want.last) begin
                    $display("%0t: expected byte %02h last %0b, got byte %02h last %0b",
                             $time, want.val, want.last, m_tdata, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tuser    = MODE_HDR;
        s_tdata    = '0;
        run_status = 8'h00;
        pay_left   = 28'd0;

        // Directed events; the typed rows can be read straight off the
        // encoding rules, the rest go through the model.
        // status below 0x80 equal to the reset running status: delta only
        dir_tab.push_back('{hdr_item(28'd0, 8'h00, 8'h00, 8'h00, 28'd0),
                            1'b1, 4'd1, 1'b1, 88'h00});
        dir_tab.push_back('{hdr_item(28'h7F, ST_NOTE_ON | 8'h03, 8'h3C, 8'h64, 28'd0),
                            1'b1, 4'd4, 1'b1, 88'h7F933C64});
        // running status: same note-on status, left out
        dir_tab.push_back('{hdr_item(28'h80, ST_NOTE_ON | 8'h03, 8'h00, 8'h00, 28'd0),
                            1'b1, 4'd4, 1'b1, 88'h81000000});
        dir_tab.push_back('{hdr_item(28'h3FFF, ST_NOTE_OFF, 8'hFF, 8'hFF, 28'd0),
                            1'b1, 4'd5, 1'b1, 88'hFF7F80FFFF});
        dir_tab.push_back('{hdr_item(28'h4000, ST_NOTE_OFF, 8'h7F, 8'h40, 28'd0),
                            1'b1, 4'd5, 1'b1, 88'h8180007F40});
        dir_tab.push_back('{hdr_item(28'h1FFFFF, ST_POLY_AT | 8'h0F, 8'h01, 8'h80, 28'd0),
                            1'b1, 4'd6, 1'b1, 88'hFFFF7FAF0180});
        // saturated delta: four groups
        dir_tab.push_back('{hdr_item(28'hFFFFFFF, ST_BEND | 8'h01, 8'h00, 8'h40, 28'd0),
                            1'b1, 4'd7, 1'b1, 88'hFFFFFF7FE10040});
        dir_tab.push_back('{hdr_item(28'd0, ST_PROG | 8'h05, 8'h12, 8'h99, 28'd0),
                            1'b1, 4'd3, 1'b1, 88'h00C512});
        dir_tab.push_back('{hdr_item(28'd0, ST_PROG | 8'h05, 8'h13, 8'h00, 28'd0),
                            1'b1, 4'd2, 1'b1, 88'h0013});
        dir_tab.push_back('{hdr_item(28'd0, ST_CHAN_AT, 8'h7F, 8'h00, 28'd0),
                            1'b1, 4'd3, 1'b1, 88'h00D07F});
        dir_tab.push_back('{hdr_item(28'd0, ST_CTRL | 8'h0A, 8'h07, 8'h55, 28'd0),
                            1'b1, 4'd4, 1'b1, 88'h00BA0755});
        // not a status byte: no data bytes, then left out when repeated
        dir_tab.push_back('{hdr_item(28'd1, 8'h12, 8'hFF, 8'hFF, 28'd0),
                            1'b1, 4'd2, 1'b1, 88'h0112});
        dir_tab.push_back('{hdr_item(28'd2, 8'h12, 8'h00, 8'h00, 28'd0),
                            1'b1, 4'd1, 1'b1, 88'h02});
        // sysex with empty payload, twice: status always sent from 0xF0 up
        dir_tab.push_back('{hdr_item(28'd0, ST_SYSEX, 8'h00, 8'h00, 28'd0),
                            1'b1, 4'd3, 1'b1, 88'h00F000});
        dir_tab.push_back('{hdr_item(28'd0, ST_SYSEX, 8'h00, 8'h00, 28'd0),
                            1'b1, 4'd3, 1'b1, 88'h00F000});
        // payload byte with nothing outstanding: dropped
        dir_tab.push_back('{pay_item(8'hAA), 1'b1, 4'd0, 1'b0, 88'h0});
        // meta with a three-byte payload; the last payload byte closes it
        dir_tab.push_back('{hdr_item(28'h10, ST_META, 8'h51, 8'h00, 28'd3),
                            1'b1, 4'd4, 1'b0, 88'h10FF5103});
        dir_tab.push_back('{pay_item(8'h07), 1'b0, 4'd0, 1'b0, 88'h0});
        dir_tab.push_back('{pay_item(8'hA1), 1'b0, 4'd0, 1'b0, 88'h0});
        dir_tab.push_back('{pay_item(8'h20), 1'b0, 4'd0, 1'b0, 88'h0});
        dir_tab.push_back('{hdr_item(28'd0, ST_META, 8'h2F, 8'h00, 28'd0),
                            1'b1, 4'd4, 1'b1, 88'h00FF2F00});
        // payload cut short by a header; the stray byte after it is dropped
        dir_tab.push_back('{hdr_item(28'd0, ST_SYSEX_ESC, 8'h00, 8'h00, 28'h80),
                            1'b1, 4'd4, 1'b0, 88'h00F78100});
        dir_tab.push_back('{pay_item(8'h55), 1'b0, 4'd0, 1'b0, 88'h0});
        dir_tab.push_back('{hdr_item(28'h7F, ST_NOTE_ON, 8'h40, 8'h7F, 28'd0),
                            1'b1, 4'd4, 1'b1, 88'h7F90407F});
        dir_tab.push_back('{pay_item(8'h33), 1'b0, 4'd0, 1'b0, 88'h0});
        // longest header: saturated delta and length, ten bytes, none closing
        dir_tab.push_back('{hdr_item(28'hFFFFFFF, ST_META, 8'h7F, 8'h00, 28'hFFFFFFF),
                            1'b1, 4'd10, 1'b0, 88'hFFFFFF7FFF7FFFFFFF7F});
        // other system status: no type byte
        dir_tab.push_back('{hdr_item(28'd0, ST_CLOCK, 8'h11, 8'h22, 28'd0),
                            1'b1, 4'd3, 1'b1, 88'h00F800});

        // hold reset, then release it on a falling edge
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i])
            send_req(dir_tab[i]);
        drain_track();
        events_sent = 0;

        // Random sequences in four idling mixes; the first one starts with a
        // long receiver hold-off so the block backs up onto its input. The
        // sender pauses for the track to drain between mixes.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    gap_pct = 0;  stall_pct = 0;
                    hold_req = 1'b1;
                end
                1: begin
                    gap_pct = 46; stall_pct = 0;
                end
                2: begin
                    gap_pct = 0;  stall_pct = 46;
                end
                default: begin
                    gap_pct = 16; stall_pct = 16;
                end
            endcase
            while (events_sent < 40 * (ph + 1))
                send_random_event();
            drain_track();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_bytes.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/mee_pkg.sv
hw/rtl/mee_sequencer.sv
hw/rtl/mee_datapath.sv
hw/rtl/midi_event_encoder.sv
sim/tb.sv
